// File: sv/cenum_pkg.sv
// Shared types and constants of the combination enumerator.
package cenum_pkg;

   // Field and register widths of the ports
   localparam int unsigned OPCODE_W      = 2;
   localparam int unsigned ENTRY_IDX_W   = 5;
   localparam int unsigned ENTRY_VAL_W   = 32;
   localparam int unsigned ELEM_VAL_W    = 32;
   localparam int unsigned POSITION_W    = 4;
   localparam int unsigned SET_SIZE_W    = 6;
   localparam int unsigned PICK_SIZE_W   = 5;
   localparam int unsigned LIMIT_W       = 30;
   localparam int unsigned CSR_IDX_W     = 2;
   localparam int unsigned CSR_DATA_W    = 30;

   // Register reset values
   localparam logic [SET_SIZE_W-1:0]  SET_SIZE_RST  = 6'd4;
   localparam logic [PICK_SIZE_W-1:0] PICK_SIZE_RST = 5'd2;
   localparam logic [LIMIT_W-1:0]     LIMIT_RST     = 30'h3FFF_FFFF;

   // Result queue geometry
   localparam int unsigned OUT_DEPTH = 4;
   localparam int unsigned OUT_PTR_W = 2;
   localparam int unsigned OUT_CNT_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_RESTART = 2'd1,
      OP_NEXT    = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SET_SIZE  = 2'd0,
      REG_PICK_SIZE = 2'd1,
      REG_LIMIT     = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic load;
      logic restart;
      logic emit_start;
      logic issue;
      logic done_push;
      logic refill_start;
      logic refill_step;
      logic set_exhausted;
   } dp_cmd_type;

   typedef struct packed {
      logic done_cond;
      logic space_ok;
      logic pipe_empty;
      logic issue_last;
      logic refill_last;
      logic adv_found;
   } dp_status_type;

   typedef struct packed {
      logic [ELEM_VAL_W-1:0] value;
      logic [POSITION_W-1:0] position;
      logic                  last;
      logic                  done;
   } rsp_entry_type;

endpackage

// File: sv/combination_enumerator_top.sv
// Top level of the lexicographic k-combination enumerator.
// The block walks the k-element combinations of the first n table entries in
// lexicographic index order. A load request (opcode load) writes one table
// entry; every entry below n must be loaded before combinations are asked
// for. A restart request sets the indices back to 0,1,...,k-1 and clears the
// emitted count. A next request emits the current combination as k results,
// one per position, with last on the final one, then moves to the successor.
// When the walk is exhausted, the count limit is reached, k is zero or k
// exceeds n, a next request gives one result with done_res and last set
// instead. A next request is accepted, then issues one position per cycle,
// while the result queue has room, through the two-stage read pipeline
// (index store, then element table), drains it, then rewrites the indices
// of the advance, from the moved position to k-1 (none when the walk runs
// out). Results pass through a four-entry queue; issue holds off once the
// queued results and those still in the read pipeline reach four.
// Configuration is to be written by the user only while the block is idle;
// the block itself does not enforce this.
module combination_enumerator_top #(
   parameter int unsigned MAX_SET     = 32,
   parameter int unsigned MAX_PICK    = 16,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [cenum_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cenum_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cenum_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [cenum_pkg::ENTRY_IDX_W-1:0]   req_entry_index,
   input  logic [cenum_pkg::ENTRY_VAL_W-1:0]   req_entry_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cenum_pkg::ELEM_VAL_W-1:0]    rsp_element_value,
   output logic [cenum_pkg::POSITION_W-1:0]    rsp_position,
   output logic                                rsp_last,
   output logic                                rsp_done_res
);
   import cenum_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer: decode the request, step through emit, drain, refill and done output
   cenum_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   // Storage, read pipeline, advance logic and result queue
   cenum_dp #(
      .MAX_SET     (MAX_SET),
      .MAX_PICK    (MAX_PICK),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element_value (rsp_element_value),
      .rsp_position      (rsp_position),
      .rsp_last          (rsp_last),
      .rsp_done_res      (rsp_done_res)
   );

   // An accepted next request always holds off the following request
   a_next_busy : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_opcode == OP_NEXT)) |=> req_stall)
      else $error("next request did not hold off the input");

   // Indices are rewritten only after every read of the pass has retired
   a_refill_after_drain : assert property (@(posedge clock) disable iff (reset)
      dp_cmd.refill_step |-> dp_status.pipe_empty)
      else $error("index refill overlaps the read pipeline");

   // At most one request-driven action per cycle
   a_one_action : assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.load, dp_cmd.restart, dp_cmd.emit_start, dp_cmd.done_push}))
      else $error("conflicting datapath commands");

   // A done result is always the only, hence last, result of its request
   a_done_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_last && (rsp_position == '0)))
      else $error("done result without last mark");

endmodule

// File: sv/cenum_ctrl.sv
// Sequencing state machine of the combination enumerator.
module cenum_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [cenum_pkg::OPCODE_W-1:0]    req_opcode,
   output logic                              req_stall,
   input  cenum_pkg::dp_status_type          status,
   output cenum_pkg::dp_cmd_type             cmd
);
   import cenum_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT,
      ST_DRAIN,
      ST_REFILL,
      ST_DONE_OUT
   } state_type;

   state_type state_ff;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      if (accept) begin
         unique case (req_opcode)
            OP_LOAD:    cmd.load = 1'b1;
            OP_RESTART: cmd.restart = 1'b1;
            OP_NEXT:    cmd.emit_start = !status.done_cond;
            default:    cmd = '0;
         endcase
      end
      cmd.issue         = (state_ff == ST_EMIT) && status.space_ok;
      cmd.done_push     = (state_ff == ST_DONE_OUT) && status.space_ok;
      cmd.refill_start  = (state_ff == ST_DRAIN) && status.pipe_empty && status.adv_found;
      cmd.set_exhausted = (state_ff == ST_DRAIN) && status.pipe_empty && !status.adv_found;
      cmd.refill_step   = (state_ff == ST_REFILL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_opcode == OP_NEXT)) begin
                  state_ff <= status.done_cond ? ST_DONE_OUT : ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (status.space_ok && status.issue_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (status.pipe_empty) begin
                  state_ff <= status.adv_found ? ST_REFILL : ST_IDLE;
               end
            end
            ST_REFILL: begin
               if (status.refill_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DONE_OUT: begin
               if (status.space_ok) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: sv/cenum_dp.sv
// Datapath of the combination enumerator: tables, read pipeline, advance and result queue.
module cenum_dp #(
   parameter int unsigned MAX_SET     = 32,
   parameter int unsigned MAX_PICK    = 16,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cenum_pkg::dp_cmd_type               cmd,
   output cenum_pkg::dp_status_type            status,
   input  logic                                csr_wr_en,
   input  logic [cenum_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cenum_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [cenum_pkg::ENTRY_IDX_W-1:0]   req_entry_index,
   input  logic [cenum_pkg::ENTRY_VAL_W-1:0]   req_entry_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cenum_pkg::ELEM_VAL_W-1:0]    rsp_element_value,
   output logic [cenum_pkg::POSITION_W-1:0]    rsp_position,
   output logic                                rsp_last,
   output logic                                rsp_done_res
);
   import cenum_pkg::*;

   localparam int unsigned TW    = $clog2(MAX_SET);
   localparam int unsigned PW    = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
   localparam int unsigned KW    = $clog2(MAX_PICK + 1);
   localparam int unsigned NW    = $clog2(MAX_SET + 1);
   localparam int unsigned IDX_W = (MAX_SET > MAX_PICK) ? $clog2(MAX_SET) : $clog2(MAX_PICK);
   localparam int unsigned CW    = $clog2(MAX_SET + MAX_PICK + 1) + 1;
   localparam int unsigned SW    = ((NW > SET_SIZE_W) ? NW : SET_SIZE_W) + 1;
   localparam int unsigned KSW   = ((KW > PICK_SIZE_W) ? KW : PICK_SIZE_W) + 1;
   localparam int unsigned OSW   = OUT_CNT_W + 1;

   // Configuration registers
   logic [SET_SIZE_W-1:0]  set_size_ff;
   logic [PICK_SIZE_W-1:0] pick_size_ff;
   logic [LIMIT_W-1:0]     limit_ff;

   // Enumeration state
   logic [LIMIT_W-1:0]     emitted_count_ff;
   logic                   exhausted_ff;
   logic [IDX_W-1:0]       chosen_mem [MAX_PICK];
   logic [MAX_PICK-1:0]    chosen_vld_ff;
   logic [VALUE_WIDTH-1:0] tab_mem [MAX_SET];

   // Read pipeline
   logic [KW-1:0]          issue_pos_ff;
   logic [IDX_W-1:0]       chosen_q_ff;
   logic                   chosen_vq_ff;
   logic                   s1_valid_ff;
   logic [PW-1:0]          s1_pos_ff;
   logic                   s1_last_ff;
   logic                   s2_valid_ff;
   logic [POSITION_W-1:0]  s2_pos_ff;
   logic                   s2_last_ff;
   logic                   s2_inr_ff;
   logic [VALUE_WIDTH-1:0] tab_q_ff;

   // Advance tracking and refill
   logic                   adv_found_ff;
   logic [PW-1:0]          adv_idx_ff;
   logic [IDX_W-1:0]       adv_val_ff;
   logic [PW-1:0]          wr_ptr_ff;
   logic [IDX_W-1:0]       wr_val_ff;

   // Result queue
   rsp_entry_type          fifo_mem [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]   fifo_wp_ff;
   logic [OUT_PTR_W-1:0]   fifo_rp_ff;
   logic [OUT_CNT_W-1:0]   fifo_cnt_ff;

   logic [NW-1:0]          n_eff;
   logic [KW-1:0]          k_eff;
   logic [IDX_W-1:0]       idx_s1;
   logic [CW-1:0]          ceil_s1;
   logic                   can_adv;
   logic [OSW-1:0]         occ;
   logic                   push;
   logic                   pop;
   rsp_entry_type          push_entry;

   // Saturate n and k to the table and index store sizes
   always_comb begin
      if (SW'(set_size_ff) > SW'(MAX_SET)) begin
         n_eff = NW'(MAX_SET);
      end else begin
         n_eff = NW'(set_size_ff);
      end
      if (KSW'(pick_size_ff) > KSW'(MAX_PICK)) begin
         k_eff = KW'(MAX_PICK);
      end else begin
         k_eff = KW'(pick_size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff  <= SET_SIZE_RST;
         pick_size_ff <= PICK_SIZE_RST;
         limit_ff     <= LIMIT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SET_SIZE:  set_size_ff  <= csr_wdata[SET_SIZE_W-1:0];
            REG_PICK_SIZE: pick_size_ff <= csr_wdata[PICK_SIZE_W-1:0];
            REG_LIMIT:     limit_ff     <= csr_wdata[LIMIT_W-1:0];
            default:       limit_ff     <= limit_ff;
         endcase
      end
   end

   // Element table: one write port for loads, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load && (CW'(req_entry_index) < CW'(MAX_SET))) begin
         tab_mem[TW'(req_entry_index)] <= VALUE_WIDTH'(req_entry_value);
      end
      if (s1_valid_ff) begin
         tab_q_ff <= tab_mem[TW'(idx_s1)];
      end
   end

   // Chosen indices: refill writes, issue reads
   always_ff @(posedge clock) begin
      if (cmd.refill_step) begin
         chosen_mem[wr_ptr_ff] <= wr_val_ff;
      end
      if (cmd.issue) begin
         chosen_q_ff  <= chosen_mem[PW'(issue_pos_ff)];
         chosen_vq_ff <= chosen_vld_ff[PW'(issue_pos_ff)];
      end
   end

   // A position never refilled since restart holds its own index
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         chosen_vld_ff <= '0;
      end else if (cmd.refill_step) begin
         chosen_vld_ff[wr_ptr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         emitted_count_ff <= '0;
         exhausted_ff     <= 1'b0;
      end else begin
         if (cmd.emit_start) begin
            emitted_count_ff <= emitted_count_ff + LIMIT_W'(1);
         end
         if (cmd.set_exhausted) begin
            exhausted_ff <= 1'b1;
         end
      end
   end

   assign idx_s1  = chosen_vq_ff ? chosen_q_ff : IDX_W'(s1_pos_ff);
   assign ceil_s1 = CW'(n_eff) - CW'(k_eff) + CW'(s1_pos_ff);
   assign can_adv = (CW'(idx_s1) < ceil_s1);

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_pos_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         adv_found_ff <= 1'b0;
      end else begin
         if (cmd.emit_start) begin
            issue_pos_ff <= '0;
         end else if (cmd.issue) begin
            issue_pos_ff <= issue_pos_ff + KW'(1);
         end
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         // Keep the rightmost position that can still move up
         if (cmd.emit_start) begin
            adv_found_ff <= 1'b0;
         end else if (s1_valid_ff && can_adv) begin
            adv_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_pos_ff  <= PW'(issue_pos_ff);
         s1_last_ff <= status.issue_last;
      end
      if (s1_valid_ff) begin
         s2_pos_ff  <= POSITION_W'(s1_pos_ff);
         s2_last_ff <= s1_last_ff;
         s2_inr_ff  <= (CW'(idx_s1) < CW'(MAX_SET));
      end
      if (s1_valid_ff && can_adv) begin
         adv_idx_ff <= s1_pos_ff;
         adv_val_ff <= idx_s1;
      end
      if (cmd.refill_start) begin
         wr_ptr_ff <= adv_idx_ff;
         wr_val_ff <= adv_val_ff + IDX_W'(1);
      end else if (cmd.refill_step) begin
         wr_ptr_ff <= wr_ptr_ff + PW'(1);
         wr_val_ff <= wr_val_ff + IDX_W'(1);
      end
   end

   // Result queue
   always_comb begin
      if (s2_valid_ff) begin
         push_entry.value    = s2_inr_ff ? ELEM_VAL_W'(tab_q_ff) : '0;
         push_entry.position = s2_pos_ff;
         push_entry.last     = s2_last_ff;
         push_entry.done     = 1'b0;
      end else begin
         push_entry.value    = '0;
         push_entry.position = '0;
         push_entry.last     = 1'b1;
         push_entry.done     = 1'b1;
      end
   end

   assign push = s2_valid_ff || cmd.done_push;
   assign pop  = (fifo_cnt_ff != '0) && !rsp_stall;
   assign occ  = OSW'(fifo_cnt_ff) + OSW'(s1_valid_ff) + OSW'(s2_valid_ff);

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[fifo_wp_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wp_ff  <= '0;
         fifo_rp_ff  <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (push) begin
            fifo_wp_ff <= fifo_wp_ff + OUT_PTR_W'(1);
         end
         if (pop) begin
            fifo_rp_ff <= fifo_rp_ff + OUT_PTR_W'(1);
         end
         if (push && !pop) begin
            fifo_cnt_ff <= fifo_cnt_ff + OUT_CNT_W'(1);
         end else if (pop && !push) begin
            fifo_cnt_ff <= fifo_cnt_ff - OUT_CNT_W'(1);
         end
      end
   end

   assign rsp_valid         = (fifo_cnt_ff != '0);
   assign rsp_element_value = fifo_mem[fifo_rp_ff].value;
   assign rsp_position      = fifo_mem[fifo_rp_ff].position;
   assign rsp_last          = fifo_mem[fifo_rp_ff].last;
   assign rsp_done_res      = fifo_mem[fifo_rp_ff].done;

   always_comb begin
      status.done_cond   = exhausted_ff || (emitted_count_ff >= limit_ff) || (k_eff == '0) ||
                           (CW'(k_eff) > CW'(n_eff));
      status.space_ok    = (occ < OSW'(OUT_DEPTH));
      status.pipe_empty  = !s1_valid_ff && !s2_valid_ff;
      status.issue_last  = (issue_pos_ff == (k_eff - KW'(1)));
      status.refill_last = (KW'(wr_ptr_ff) == (k_eff - KW'(1)));
      status.adv_found   = adv_found_ff;
   end

endmodule
